// ===== hw/rtl/gdc_pkg.sv =====
// Shared types, constants and calendar helper functions of the Gregorian date counter.
package gdc_pkg;

	localparam logic [13:0] YEAR_MAX = 14'd9999;

	localparam logic [1:0] OP_FWD  = 2'd0;
	localparam logic [1:0] OP_BACK = 2'd1;
	localparam logic [1:0] OP_LOAD = 2'd2;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	// Multiplicative inverse of 25 modulo 2**14, and the largest product
	// that marks a multiple of 25 (floor((2**14 - 1) / 25)).
	localparam logic [27:0] INV25      = 28'd7209;
	localparam logic [13:0] DIV25_MAX  = 14'd655;
	// 586 / 4096 slightly above 1/7; exact floor for dividends up to 372.
	localparam logic [19:0] RECIP7     = 20'd586;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [4:0]  load_day;
		logic [3:0]  load_month;
		logic [13:0] load_year;
	} req_t;

	typedef struct packed {
		logic [4:0]  day_of_month;
		logic [3:0]  month_number;
		logic [13:0] year_number;
		logic        leap_flag;
		logic [8:0]  day_of_year;
		logic [5:0]  week_of_year;
		logic        error_flag;
	} rsp_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [8:0]  ordinal;
		logic        leap;
	} date_t;

	localparam date_t DATE_RESET = '{day: 5'd1, month: 4'd7, year: 14'd2004,
		ordinal: 9'd183, leap: 1'b1};

	// A year is a multiple of 100 when it is a multiple of 4 and of 25,
	// and a multiple of 400 when it is a multiple of 16 and of 25.
	function automatic logic is_leap(input logic [13:0] y);
		logic [27:0] prod;
		logic        div4;
		logic        div16;
		logic        div25;
		prod  = {14'd0, y} * INV25;
		div4  = (y[1:0] == 2'd0);
		div16 = (y[3:0] == 4'd0);
		div25 = (prod[13:0] <= DIV25_MAX);
		return div4 && (!div25 || div16);
	endfunction

	function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     d = 5'd30;
			4'd2:                                        d = leap ? 5'd29 : 5'd28;
			default:                                     d = 5'd0;
		endcase
		return d;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// Ceiling of ordinal / 7 as floor((ordinal + 6) * 586 / 4096).
	function automatic logic [5:0] week_of(input logic [8:0] ord);
		logic [19:0] prod;
		prod = ({11'd0, ord} + 20'd6) * RECIP7;
		return prod[17:12];
	endfunction

endpackage

// ===== hw/rtl/gdc_step.sv =====
// Next-date logic: applies one command to the held date and flags refused commands.
module gdc_step import gdc_pkg::*; (
	input  date_t cur,
	input  req_t  req,
	output date_t nxt,
	output logic  err
);

	logic [4:0]  cur_dim;
	logic [4:0]  prev_dim;
	logic [3:0]  prev_month;
	logic        up_leap;
	logic        down_leap;
	logic        ld_leap;
	logic [4:0]  ld_dim;
	logic        ld_ok;
	logic [8:0]  ld_ord;

	assign cur_dim    = days_in(cur.month, cur.leap);
	assign prev_month = cur.month - 4'd1;
	assign prev_dim   = days_in(prev_month, cur.leap);
	assign up_leap    = is_leap(cur.year + 14'd1);
	assign down_leap  = is_leap(cur.year - 14'd1);

	assign ld_leap = is_leap(req.load_year);
	assign ld_dim  = days_in(req.load_month, ld_leap);
	assign ld_ok   = (req.load_month >= MONTH_JAN) && (req.load_month <= MONTH_DEC)
		&& (req.load_year != 14'd0) && (req.load_year <= YEAR_MAX)
		&& (req.load_day != 5'd0) && (req.load_day <= ld_dim);
	assign ld_ord  = days_before(req.load_month) + {4'd0, req.load_day}
		+ {8'd0, (req.load_month > MONTH_FEB) && ld_leap};

	always_comb begin
		nxt = cur;
		err = 1'b0;
		unique case (req.opcode)
			OP_FWD: begin
				if (cur.day < cur_dim) begin
					nxt.day     = cur.day + 5'd1;
					nxt.ordinal = cur.ordinal + 9'd1;
				end else if (cur.month < MONTH_DEC) begin
					nxt.day     = 5'd1;
					nxt.month   = cur.month + 4'd1;
					nxt.ordinal = cur.ordinal + 9'd1;
				end else if (cur.year < YEAR_MAX) begin
					nxt.day     = 5'd1;
					nxt.month   = MONTH_JAN;
					nxt.year    = cur.year + 14'd1;
					nxt.ordinal = 9'd1;
					nxt.leap    = up_leap;
				end else begin
					err = 1'b1;
				end
			end
			OP_BACK: begin
				if (cur.day > 5'd1) begin
					nxt.day     = cur.day - 5'd1;
					nxt.ordinal = cur.ordinal - 9'd1;
				end else if (cur.month > MONTH_JAN) begin
					nxt.month   = prev_month;
					nxt.day     = prev_dim;
					nxt.ordinal = cur.ordinal - 9'd1;
				end else if (cur.year > 14'd1) begin
					nxt.year    = cur.year - 14'd1;
					nxt.month   = MONTH_DEC;
					nxt.day     = 5'd31;
					nxt.ordinal = down_leap ? 9'd366 : 9'd365;
					nxt.leap    = down_leap;
				end else begin
					err = 1'b1;
				end
			end
			OP_LOAD: begin
				if (ld_ok) begin
					nxt.day     = req.load_day;
					nxt.month   = req.load_month;
					nxt.year    = req.load_year;
					nxt.ordinal = ld_ord;
					nxt.leap    = ld_leap;
				end else begin
					err = 1'b1;
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase
	end

endmodule

// ===== hw/rtl/gregorian_date_counter.sv =====
// Top level of the Gregorian date counter: request register, date state and result register.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   req     | in        | req_valid / req_stall | req_t: opcode, load date
//   rsp     | out       | rsp_valid / rsp_stall | rsp_t: date, leap, ordinal, week
//
// One request is taken per cycle while req_stall is low. An accepted request
// sits in the request register, where the step logic applies it to the held
// date; the edge that moves it on writes the new date and the result register
// together, so a result reaches rsp through the request register and the
// result register. The date update is one pass of short logic (three constant
// multiplies for the leap test, one for the week) and feeds back on itself,
// so a new request can be applied as soon as the last one moves on.
// Reset sets the date to 1 July 2004 and empties both registers.
// A stall on rsp holds the result and, once the request register is also full,
// stalls req in the same cycle.
module gregorian_date_counter import gdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic  valid_s1;
	req_t  req_s1;
	date_t date_q;
	date_t date_nxt;
	logic  step_err;
	logic  advance;
	logic  rsp_valid_q;
	rsp_t  rsp_q;

	// The held request moves on whenever the result register is free or
	// being emptied in this same cycle.
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	gdc_step u_step (
		.cur (date_q),
		.req (req_s1),
		.nxt (date_nxt),
		.err (step_err)
	);

	// The held date only changes when a request is applied; a refused
	// request leaves it as it was since the step logic then returns it unchanged.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_q <= DATE_RESET;
		end else if (advance) begin
			date_q <= date_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.day_of_month <= date_nxt.day;
			rsp_q.month_number <= date_nxt.month;
			rsp_q.year_number  <= date_nxt.year;
			rsp_q.leap_flag    <= date_nxt.leap;
			rsp_q.day_of_year  <= date_nxt.ordinal;
			rsp_q.week_of_year <= week_of(date_nxt.ordinal);
			rsp_q.error_flag   <= step_err;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The stored leap bit always matches the stored year.
	assert property (@(posedge clk) disable iff (!arst_n)
		date_q.leap == is_leap(date_q.year))
		else $error("stored leap bit disagrees with stored year");

	// A refused request must leave the date untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_err |=> $stable(date_q))
		else $error("refused request changed the date");

	// Every applied request shows up as a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid && (rsp.day_of_year == date_q.ordinal))
		else $error("result missing or not matching the held date");

	// The held ordinal stays consistent with day and month.
	assert property (@(posedge clk) disable iff (!arst_n)
		date_q.ordinal == days_before(date_q.month) + {4'd0, date_q.day}
			+ {8'd0, (date_q.month > MONTH_FEB) && date_q.leap})
		else $error("ordinal out of step with day and month");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the Gregorian date counter: directed table, random commands, random idling.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import gdc_pkg::*;

	// The opcode that the package leaves unnamed; the block must refuse it.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Values of the error flag in a result.
	localparam logic CMD_DONE    = 1'b0;
	localparam logic CMD_REFUSED = 1'b1;

	// A row of the directed table either carries its expected result typed in,
	// or leaves it to the calendar predictor below.
	localparam bit   KNOWN   = 1'b1;
	localparam bit   PREDICT = 1'b0;
	localparam rsp_t NO_WANT = '0;

	localparam int PLAN_ROWS    = 25;
	localparam int RANDOM_ITEMS = 1200;
	localparam int HALF_PERIOD  = 5;
	// The slowest correct run is about 1230 requests, each waiting out the
	// longest sender gap, the longest receiver stall and the block's latency.
	// The limit is several times that.
	localparam int LIMIT_CYCLES = 200000;
	// A result leaves the block once its request has passed the request and result registers.
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		req_t cmd;
		bit   known;
		rsp_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// Results still owed by the block, oldest first.
	rsp_t awaited_reports [$];
	rsp_t oldest_report;
	int   mismatches = 0;
	int   cycle_count = 0;
	// While set, both sides run back to back with no idle cycles.
	bit   steady = 1'b0;

	// The date that the block should hold, tracked independently of it.
	int held_day   = 1;
	int held_month = 7;
	int held_year  = 2004;
	int held_ord   = 183;

	plan_row_t plan [0:PLAN_ROWS-1];

	gregorian_date_counter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Gregorian leap rule: every fourth year, except centuries not divisible by 400.
	function automatic bit leap_of(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	// Length of month m in year y, zero for a month outside 1..12.
	function automatic int month_length(input int m, input int y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_of(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// Applies one command to the held date and returns the result that the
	// block should report for it. Refused commands leave the date alone.
	function automatic rsp_t next_date_report(input req_t cmd);
		rsp_t rep;
		logic refused;
		int   ld;
		int   lm;
		int   ly;
		ld = int'(cmd.load_day);
		lm = int'(cmd.load_month);
		ly = int'(cmd.load_year);
		refused = CMD_DONE;
		case (cmd.opcode)
			OP_FWD: begin
				if (held_day < month_length(held_month, held_year)) begin
					held_day++;
					held_ord++;
				end else if (held_month < 12) begin
					held_day = 1;
					held_month++;
					held_ord++;
				end else if (held_year < YEAR_MAX) begin
					held_day = 1;
					held_month = 1;
					held_year++;
					held_ord = 1;
				end else begin
					refused = CMD_REFUSED;
				end
			end
			OP_BACK: begin
				if (held_day > 1) begin
					held_day--;
					held_ord--;
				end else if (held_month > 1) begin
					held_month--;
					held_day = month_length(held_month, held_year);
					held_ord--;
				end else if (held_year > 1) begin
					held_year--;
					held_month = 12;
					held_day = 31;
					held_ord = leap_of(held_year) ? 366 : 365;
				end else begin
					refused = CMD_REFUSED;
				end
			end
			OP_LOAD: begin
				if (lm >= 1 && lm <= 12 && ly >= 1 && ly <= YEAR_MAX &&
						ld >= 1 && ld <= month_length(lm, ly)) begin
					held_day = ld;
					held_month = lm;
					held_year = ly;
					held_ord = ld;
					for (int k = 1; k < lm; k++)
						held_ord += month_length(k, ly);
				end else begin
					refused = CMD_REFUSED;
				end
			end
			default: refused = CMD_REFUSED;
		endcase
		rep.day_of_month = 5'(held_day);
		rep.month_number = 4'(held_month);
		rep.year_number  = 14'(held_year);
		rep.leap_flag    = leap_of(held_year);
		rep.day_of_year  = 9'(held_ord);
		rep.week_of_year = 6'((held_ord + 6) / 7);
		rep.error_flag   = refused;
		return rep;
	endfunction

	// One line per mismatch; after the first fifty only the count goes on.
	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 50)
			$display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic int pick_gap();
		return steady ? 0 : $urandom_range(0, 12);
	endfunction

	// Offers one request after a random number of idle cycles and holds it
	// until the block takes it. The expected result is queued at the edge
	// that accepts the request, so the predictor sees requests in order.
	task automatic send_request(input req_t cmd, input bit known, input rsp_t want);
		int   gap;
		rsp_t predicted;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= cmd;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predicted = next_date_report(cmd);
		awaited_reports.push_back(known ? want : predicted);
	endtask

	// Lowers valid and waits until the block has returned every result.
	task automatic wait_until_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
	endtask

	// Receiver: before each result it may hold stall high for a random number
	// of cycles, whether a result is waiting or not, so stalls land on every
	// phase of the block's two-stage flow.
	initial begin
		int hold;
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = pick_gap();
			@(negedge clk);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	// Result checker: every accepted result is matched field by field with
	// the oldest expectation. Values are read at the rising edge, before the
	// block's own registers update.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_reports.size() == 0) begin
				report_mismatch("unexpected result, day_of_month", rsp.day_of_month, 0);
			end else begin
				oldest_report = awaited_reports.pop_front();
				if (rsp.day_of_month !== oldest_report.day_of_month)
					report_mismatch("day_of_month", rsp.day_of_month,
						oldest_report.day_of_month);
				if (rsp.month_number !== oldest_report.month_number)
					report_mismatch("month_number", rsp.month_number,
						oldest_report.month_number);
				if (rsp.year_number !== oldest_report.year_number)
					report_mismatch("year_number", rsp.year_number,
						oldest_report.year_number);
				if (rsp.leap_flag !== oldest_report.leap_flag)
					report_mismatch("leap_flag", rsp.leap_flag, oldest_report.leap_flag);
				if (rsp.day_of_year !== oldest_report.day_of_year)
					report_mismatch("day_of_year", rsp.day_of_year,
						oldest_report.day_of_year);
				if (rsp.week_of_year !== oldest_report.week_of_year)
					report_mismatch("week_of_year", rsp.week_of_year,
						oldest_report.week_of_year);
				if (rsp.error_flag !== oldest_report.error_flag)
					report_mismatch("error_flag", rsp.error_flag, oldest_report.error_flag);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_reports.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		req_t        cmd;
		logic [31:0] junk;
		int          pick;
		int          d;
		int          m;
		int          y;
		int          last;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;

		// Directed table. Each row is {opcode, day, month, year, known,
		// expected day, month, year, leap, day of year, week, error}.
		// The unused opcode comes first, with every load bit set, so the
		// reset date shows up unchanged and refused.
		plan[0]  = {OP_UNUSED, 5'd31, 4'd15, 14'd16383, KNOWN,
			5'd1, 4'd7, 14'd2004, 1'b1, 9'd183, 6'd27, CMD_REFUSED};
		plan[1]  = {OP_FWD,  5'd0, 4'd0, 14'd0, PREDICT, NO_WANT};
		plan[2]  = {OP_BACK, 5'd0, 4'd0, 14'd0, PREDICT, NO_WANT};
		// Last day of the last year, then a step past the top.
		plan[3]  = {OP_LOAD, 5'd31, 4'd12, 14'd9999, KNOWN,
			5'd31, 4'd12, 14'd9999, 1'b0, 9'd365, 6'd53, CMD_DONE};
		plan[4]  = {OP_FWD,  5'd0, 4'd0, 14'd0, KNOWN,
			5'd31, 4'd12, 14'd9999, 1'b0, 9'd365, 6'd53, CMD_REFUSED};
		// First day of year one, then a step below it.
		plan[5]  = {OP_LOAD, 5'd1, 4'd1, 14'd1, KNOWN,
			5'd1, 4'd1, 14'd1, 1'b0, 9'd1, 6'd1, CMD_DONE};
		plan[6]  = {OP_BACK, 5'd0, 4'd0, 14'd0, KNOWN,
			5'd1, 4'd1, 14'd1, 1'b0, 9'd1, 6'd1, CMD_REFUSED};
		// Invalid loads: day zero, month zero, month 13, year zero, year
		// above the top, 29 February of a century year, 31 April.
		plan[7]  = {OP_LOAD, 5'd0, 4'd1, 14'd2000, KNOWN,
			5'd1, 4'd1, 14'd1, 1'b0, 9'd1, 6'd1, CMD_REFUSED};
		plan[8]  = {OP_LOAD, 5'd1, 4'd0, 14'd2000, KNOWN,
			5'd1, 4'd1, 14'd1, 1'b0, 9'd1, 6'd1, CMD_REFUSED};
		plan[9]  = {OP_LOAD, 5'd1, 4'd13, 14'd2000, KNOWN,
			5'd1, 4'd1, 14'd1, 1'b0, 9'd1, 6'd1, CMD_REFUSED};
		plan[10] = {OP_LOAD, 5'd1, 4'd1, 14'd0, KNOWN,
			5'd1, 4'd1, 14'd1, 1'b0, 9'd1, 6'd1, CMD_REFUSED};
		plan[11] = {OP_LOAD, 5'd1, 4'd1, 14'd10000, KNOWN,
			5'd1, 4'd1, 14'd1, 1'b0, 9'd1, 6'd1, CMD_REFUSED};
		plan[12] = {OP_LOAD, 5'd29, 4'd2, 14'd1900, KNOWN,
			5'd1, 4'd1, 14'd1, 1'b0, 9'd1, 6'd1, CMD_REFUSED};
		plan[13] = {OP_LOAD, 5'd31, 4'd4, 14'd2001, KNOWN,
			5'd1, 4'd1, 14'd1, 1'b0, 9'd1, 6'd1, CMD_REFUSED};
		// Leap day of a 400-year, and the month boundary around it.
		plan[14] = {OP_LOAD, 5'd29, 4'd2, 14'd2000, KNOWN,
			5'd29, 4'd2, 14'd2000, 1'b1, 9'd60, 6'd9, CMD_DONE};
		plan[15] = {OP_FWD,  5'd0, 4'd0, 14'd0, PREDICT, NO_WANT};
		plan[16] = {OP_BACK, 5'd0, 4'd0, 14'd0, PREDICT, NO_WANT};
		// End of February in a century year that is not a leap year.
		plan[17] = {OP_LOAD, 5'd28, 4'd2, 14'd1900, KNOWN,
			5'd28, 4'd2, 14'd1900, 1'b0, 9'd59, 6'd9, CMD_DONE};
		plan[18] = {OP_FWD,  5'd0, 4'd0, 14'd0, PREDICT, NO_WANT};
		// Day 366 of a leap year and the year boundary both ways.
		plan[19] = {OP_LOAD, 5'd31, 4'd12, 14'd2000, KNOWN,
			5'd31, 4'd12, 14'd2000, 1'b1, 9'd366, 6'd53, CMD_DONE};
		plan[20] = {OP_FWD,  5'd0, 4'd0, 14'd0, PREDICT, NO_WANT};
		plan[21] = {OP_BACK, 5'd0, 4'd0, 14'd0, PREDICT, NO_WANT};
		plan[22] = {OP_LOAD, 5'd29, 4'd2, 14'd2004, KNOWN,
			5'd29, 4'd2, 14'd2004, 1'b1, 9'd60, 6'd9, CMD_DONE};
		// Largest year the field can carry is refused.
		plan[23] = {OP_LOAD, 5'd31, 4'd12, 14'd16383, KNOWN,
			5'd29, 4'd2, 14'd2004, 1'b1, 9'd60, 6'd9, CMD_REFUSED};
		plan[24] = {OP_FWD,  5'd0, 4'd0, 14'd0, PREDICT, NO_WANT};

		// Reset is asserted once and released between edges.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i])
			send_request(plan[i].cmd, plan[i].known, plan[i].want);

		// Let the block empty out completely once before the random part.
		wait_until_drained();

		// Random part: mostly day steps, with loads biased toward month and
		// year ends, century years and the two ends of the year range, plus
		// some raw loads that are mostly refused and the unused opcode. The
		// load fields of step commands carry random bits that must be ignored.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				steady = ($urandom_range(0, 2) == 0);
			if (n == RANDOM_ITEMS / 2)
				wait_until_drained();
			junk = $urandom;
			cmd = junk[$bits(req_t)-1:0];
			pick = $urandom_range(0, 99);
			if (pick < 38) begin
				cmd.opcode = OP_FWD;
			end else if (pick < 70) begin
				cmd.opcode = OP_BACK;
			end else if (pick < 90) begin
				cmd.opcode = OP_LOAD;
				m = $urandom_range(1, 12);
				case ($urandom_range(0, 7))
					0: y = $urandom_range(1, 3);
					1: y = $urandom_range(YEAR_MAX - 2, YEAR_MAX);
					2: y = 100 * $urandom_range(1, 99);
					default: y = $urandom_range(1, YEAR_MAX);
				endcase
				last = month_length(m, y);
				case ($urandom_range(0, 3))
					0: d = 1;
					1: d = last;
					2: d = last - 1;
					default: d = $urandom_range(1, last);
				endcase
				// Now and then jump straight to one end of the range so that
				// the refused steps at the edges come up often.
				if ($urandom_range(0, 15) == 0) begin
					if ($urandom_range(0, 1) == 0) begin
						d = 31;
						m = 12;
						y = YEAR_MAX;
					end else begin
						d = 1;
						m = 1;
						y = 1;
					end
				end
				cmd.load_day = 5'(d);
				cmd.load_month = 4'(m);
				cmd.load_year = 14'(y);
			end else if (pick < 97) begin
				cmd.opcode = OP_LOAD;
			end else begin
				cmd.opcode = OP_UNUSED;
			end
			send_request(cmd, PREDICT, NO_WANT);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		// A few more cycles so that any surplus result is caught.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
